// ===== rtl/sofcrc_pkg.sv =====
// ----------------------------------------------------------------------------
// sofcrc_pkg: shared types and constants for the framed CRC-8 receiver
// Holds the frame phase type, the record passed from front to back, result
// codes and the bytewise CRC-8 update.
// ----------------------------------------------------------------------------
package sofcrc_pkg;

	localparam logic [7:0] SOF_BYTE    = 8'hAA;
	localparam logic [7:0] CRC_POLY    = 8'h07;
	localparam int         PAYLOAD_LEN = 4;
	localparam int         PAY_IDX_W   = $clog2(PAYLOAD_LEN);

	localparam int DATA_W  = 15;
	localparam int REDUN_W = 10;
	localparam int ERRCNT_W = 16;

	// default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 2;

	// result codes
	localparam logic RK_FRAME    = 1'b0;
	localparam logic RK_MISMATCH = 1'b1;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_COLLECT,
		PH_CHECK
	} phase_t;

	// one finished frame, as classified by the front
	typedef struct packed {
		logic               crc_ok;
		logic [DATA_W-1:0]  data_word;
		logic [REDUN_W-1:0] redundancy_word;
		logic               parity_bit;
	} frame_rec_t;

	// CRC-8, MSB first, no reflection, one byte
	function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] c;
		c = acc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/sof_crc8_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// sof_crc8_frame_receiver_top: framed byte receiver with CRC-8 check
// Start-byte hunt, four-byte payload, CRC-8 (poly 0x07) check byte, one
// result request per frame.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock on the in_valid/in_ready
// channel. It ignores bytes until it sees 0xAA, then stores four payload
// bytes while updating a CRC-8 (poly 0x07, init 0, MSB first) one byte per
// cycle, and compares the fifth byte with that CRC. A start byte inside a
// frame is plain data. Every check byte yields exactly one result request:
// result_kind 0 carries the unpacked data word, redundancy word and parity
// bit; result_kind 1 carries zeroed fields, the bumped 16-bit wrapping
// mismatch count in error_count and marker_request = debug_marker_enable.
// error_count always shows the count after that result. Rate: one byte per
// cycle while the frame queue has room; the CRC update in the front is
// combinational. A result passes from its check byte through the queue row,
// written on the accepting edge, and then through the output register.
// The front only stalls on a check byte when the frame queue is
// full; the queue (QUEUE_DEPTH records) lets the output side stall freely.
// Write debug_marker_enable through cfg_wr_en/cfg_wr_data only while idle.
// ----------------------------------------------------------------------------
module sof_crc8_frame_receiver_top #(
	parameter int QUEUE_DEPTH = sofcrc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_wr_en,
	input  logic                            cfg_wr_data,
	// byte input
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      rx_byte,
	// result output
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            result_kind,
	output logic [sofcrc_pkg::DATA_W-1:0]   data_word,
	output logic [sofcrc_pkg::REDUN_W-1:0]  redundancy_word,
	output logic                            parity_bit,
	output logic [sofcrc_pkg::ERRCNT_W-1:0] error_count,
	output logic                            marker_request
);
	import sofcrc_pkg::*;

	logic       debug_marker_enable_q;

	// front -> queue
	logic       push_valid;
	logic       push_ready;
	frame_rec_t push_data;

	// queue -> back
	logic       pop_valid;
	logic       pop_ready;
	frame_rec_t pop_data;

	// the one configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debug_marker_enable_q <= 1'b0;
		end else if (cfg_wr_en) begin
			debug_marker_enable_q <= cfg_wr_data;
		end
	end

	// front: hunt, collect, incremental CRC, classify
	sofcrc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// frame queue between the two halves
	sofcrc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// back: mismatch count and result register
	sofcrc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.pop_valid       (pop_valid),
		.pop_ready       (pop_ready),
		.pop_data        (pop_data),
		.marker_enable   (debug_marker_enable_q),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.result_kind     (result_kind),
		.data_word       (data_word),
		.redundancy_word (redundancy_word),
		.parity_bit      (parity_bit),
		.error_count     (error_count),
		.marker_request  (marker_request)
	);

	// a check byte must not be taken while the queue is full
	a_no_drop_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && !push_ready) |-> !in_ready)
		else $error("check byte accepted with frame queue full");

	// a popped record always shows up as a result next cycle
	a_pop_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_valid && pop_ready) |=> out_valid)
		else $error("popped frame record did not reach the output");

	// a mismatch record becomes a mismatch result with the marker setting
	a_mismatch_result: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_valid && pop_ready && !pop_data.crc_ok) |=>
		(result_kind == RK_MISMATCH && marker_request == $past(debug_marker_enable_q)
		&& error_count == $past(error_count) + 1'b1))
		else $error("mismatch result malformed");

endmodule

// ===== rtl/sofcrc_front.sv =====
// ----------------------------------------------------------------------------
// sofcrc_front: byte intake and frame classification
// Hunts for the start byte, stores the payload, updates the CRC per byte and
// pushes one frame record into the queue on the check byte.
// ----------------------------------------------------------------------------
module sofcrc_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             rx_byte,
	output logic                   push_valid,
	input  logic                   push_ready,
	output sofcrc_pkg::frame_rec_t push_data
);
	import sofcrc_pkg::*;

	phase_t               phase_q;
	phase_t               phase_d;
	logic [PAY_IDX_W-1:0] count_q;
	logic [7:0]           crc_q;
	logic [7:0]           payload_q [PAYLOAD_LEN];
	logic                 accept;

	assign accept = in_valid && in_ready;

	// next state
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_HUNT: begin
				if (accept && rx_byte == SOF_BYTE) begin
					phase_d = PH_COLLECT;
				end
			end
			PH_COLLECT: begin
				if (accept && count_q == PAY_IDX_W'(PAYLOAD_LEN - 1)) begin
					phase_d = PH_CHECK;
				end
			end
			default: begin
				// check byte; the unused code behaves the same
				if (accept) begin
					phase_d = PH_HUNT;
				end
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready   = 1'b1;
		push_valid = 1'b0;
		unique case (phase_q)
			PH_HUNT, PH_COLLECT: begin
				in_ready = 1'b1;
			end
			default: begin
				in_ready   = push_ready;
				push_valid = in_valid;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= '0;
			crc_q   <= '0;
		end else begin
			phase_q <= phase_d;
			if (accept && phase_q == PH_HUNT) begin
				count_q <= '0;
				crc_q   <= '0;
			end else if (accept && phase_q == PH_COLLECT) begin
				count_q <= count_q + 1'b1;
				crc_q   <= crc8_byte(crc_q, rx_byte);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && phase_q == PH_COLLECT) begin
			payload_q[count_q] <= rx_byte;
		end
	end

	always_comb begin
		push_data.crc_ok          = (rx_byte == crc_q);
		push_data.data_word       = {payload_q[1][6:0], payload_q[0]};
		push_data.redundancy_word = {payload_q[3][1:0], payload_q[2]};
		push_data.parity_bit      = payload_q[1][7];
	end

endmodule

// ===== rtl/sofcrc_fifo.sv =====
// ----------------------------------------------------------------------------
// sofcrc_fifo: short frame-record queue
// Decouples the byte front from the result back; full/empty by count.
// ----------------------------------------------------------------------------
module sofcrc_fifo #(
	parameter int DEPTH = sofcrc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push_valid,
	output logic                   push_ready,
	input  sofcrc_pkg::frame_rec_t push_data,
	output logic                   pop_valid,
	input  logic                   pop_ready,
	output sofcrc_pkg::frame_rec_t pop_data
);
	import sofcrc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	frame_rec_t       rows_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (cnt_q != CNT_W'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = rows_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			rows_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/sofcrc_back.sv =====
// ----------------------------------------------------------------------------
// sofcrc_back: result formation
// Pops frame records, keeps the mismatch count and holds the result in an
// output register.
// ----------------------------------------------------------------------------
module sofcrc_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pop_valid,
	output logic                            pop_ready,
	input  sofcrc_pkg::frame_rec_t          pop_data,
	input  logic                            marker_enable,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            result_kind,
	output logic [sofcrc_pkg::DATA_W-1:0]   data_word,
	output logic [sofcrc_pkg::REDUN_W-1:0]  redundancy_word,
	output logic                            parity_bit,
	output logic [sofcrc_pkg::ERRCNT_W-1:0] error_count,
	output logic                            marker_request
);
	import sofcrc_pkg::*;

	logic                out_valid_q;
	logic                kind_q;
	logic [DATA_W-1:0]   data_q;
	logic [REDUN_W-1:0]  redun_q;
	logic                parity_q;
	logic [ERRCNT_W-1:0] err_cnt_q;
	logic [ERRCNT_W-1:0] err_cnt_d;
	logic                marker_q;
	logic                do_pop;

	assign pop_ready = !out_valid_q || out_ready;
	assign do_pop    = pop_valid && pop_ready;
	assign err_cnt_d = pop_data.crc_ok ? err_cnt_q : err_cnt_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			err_cnt_q   <= '0;
		end else begin
			if (do_pop) begin
				out_valid_q <= 1'b1;
				err_cnt_q   <= err_cnt_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload; a mismatch carries zeroed frame fields
	always_ff @(posedge clk) begin
		if (do_pop) begin
			if (pop_data.crc_ok) begin
				kind_q   <= RK_FRAME;
				data_q   <= pop_data.data_word;
				redun_q  <= pop_data.redundancy_word;
				parity_q <= pop_data.parity_bit;
				marker_q <= 1'b0;
			end else begin
				kind_q   <= RK_MISMATCH;
				data_q   <= '0;
				redun_q  <= '0;
				parity_q <= 1'b0;
				marker_q <= marker_enable;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign result_kind     = kind_q;
	assign data_word       = data_q;
	assign redundancy_word = redun_q;
	assign parity_bit      = parity_q;
	assign error_count     = err_cnt_q;
	assign marker_request  = marker_q;

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for sof_crc8_frame_receiver_top
// Drives received bytes with random gaps, applies back-pressure on the result
// side, and checks every result request against a local frame decoder.
// Covers a directed table, random framed traffic and a back-to-back burst.
// ----------------------------------------------------------------------------
module tb_top;

	import sofcrc_pkg::*;

	localparam int SETTLE_CYCLES = 4;     // result passes the queue and the output register after its check byte
	localparam int STALL_LIMIT   = 1000;  // cycles with no request moving on either side
	localparam int MAX_REPORTS   = 10;
	localparam int PHASE_ITEMS   = 115;   // live bytes per random phase, six phases

	// idle styles for either side
	localparam int IDLE_NONE = 0;
	localparam int IDLE_FULL = 1;
	localparam int IDLE_SOME = 2;

	// one result request, field for field as on the ports
	typedef struct packed {
		logic                kind;
		logic [DATA_W-1:0]   data;
		logic [REDUN_W-1:0]  redun;
		logic                parity;
		logic [ERRCNT_W-1:0] errs;
		logic                marker;
	} rx_result_t;

	// how a table row (or a random frame) picks its byte
	typedef enum logic [1:0] {
		ROW_BYTE,  // byte as given
		ROW_GOOD,  // the correct check byte for the stored payload
		ROW_BAD,   // correct check byte xor the given nonzero value
		ROW_CFG    // not a byte: write debug_marker_enable from bit 0
	} row_kind_t;

	typedef struct packed {
		row_kind_t  kind;
		logic [7:0] val;
		logic       pinned;
		rx_result_t want;
	} stim_row_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic                cfg_wr_data;
	logic                in_valid;
	logic                in_ready;
	logic [7:0]          rx_byte;
	logic                out_valid;
	logic                out_ready;
	logic                result_kind;
	logic [DATA_W-1:0]   data_word;
	logic [REDUN_W-1:0]  redundancy_word;
	logic                parity_bit;
	logic [ERRCNT_W-1:0] error_count;
	logic                marker_request;

	sof_crc8_frame_receiver_top uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.result_kind     (result_kind),
		.data_word       (data_word),
		.redundancy_word (redundancy_word),
		.parity_bit      (parity_bit),
		.error_count     (error_count),
		.marker_request  (marker_request)
	);

	// ------------------------------------------------------------------
	// Local frame decoder state
	// ------------------------------------------------------------------
	phase_t              rx_phase;
	logic [2:0]          rx_cnt;
	logic [7:0]          rx_pay [PAYLOAD_LEN];
	logic [ERRCNT_W-1:0] rx_errs;
	logic                marker_en;

	// results still owed by the block, oldest first
	rx_result_t frame_results_q [$];

	int  in_mode;
	int  out_mode;
	int  n_fail;
	int  n_live;
	int  n_bytes;
	int  n_good;
	int  n_bad;
	int  n_marked;
	int  n_cfg;
	int  stall_cycles;
	bit  wrap_seen;

	// Directed table. Rows with pinned set carry a result that is plain from
	// the frame itself; all others are left to the decoder.
	localparam int N_DIR = 28;
	stim_row_t dir_rows [N_DIR] = '{
		// noise while hunting, both byte extremes
		'{ROW_BYTE, 8'h00, 1'b0, '0},
		'{ROW_BYTE, 8'hFF, 1'b0, '0},
		// all-ones payload with its correct check byte: every field at its top
		'{ROW_BYTE, SOF_BYTE, 1'b0, '0},
		'{ROW_BYTE, 8'hFF, 1'b0, '0},
		'{ROW_BYTE, 8'hFF, 1'b0, '0},
		'{ROW_BYTE, 8'hFF, 1'b0, '0},
		'{ROW_BYTE, 8'hFF, 1'b0, '0},
		'{ROW_GOOD, 8'h00, 1'b1, '{RK_FRAME, 15'h7FFF, 10'h3FF, 1'b1, 16'd0, 1'b0}},
		// zero payload has check 0x00, so 0x01 is a mismatch; markers still off
		'{ROW_BYTE, SOF_BYTE, 1'b0, '0},
		'{ROW_BYTE, 8'h00, 1'b0, '0},
		'{ROW_BYTE, 8'h00, 1'b0, '0},
		'{ROW_BYTE, 8'h00, 1'b0, '0},
		'{ROW_BYTE, 8'h00, 1'b0, '0},
		'{ROW_BYTE, 8'h01, 1'b1, '{RK_MISMATCH, 15'd0, 10'd0, 1'b0, 16'd1, 1'b0}},
		// markers on: a mismatch now raises marker_request
		'{ROW_CFG, 8'h01, 1'b0, '0},
		'{ROW_BYTE, SOF_BYTE, 1'b0, '0},
		'{ROW_BYTE, 8'h12, 1'b0, '0},
		'{ROW_BYTE, 8'h80, 1'b0, '0},
		'{ROW_BYTE, 8'h34, 1'b0, '0},
		'{ROW_BYTE, 8'hFF, 1'b0, '0},
		'{ROW_BAD, 8'h5A, 1'b1, '{RK_MISMATCH, 15'd0, 10'd0, 1'b0, 16'd2, 1'b1}},
		// start byte in every payload slot and in the check slot: plain data
		'{ROW_CFG, 8'h00, 1'b0, '0},
		'{ROW_BYTE, SOF_BYTE, 1'b0, '0},
		'{ROW_BYTE, SOF_BYTE, 1'b0, '0},
		'{ROW_BYTE, SOF_BYTE, 1'b0, '0},
		'{ROW_BYTE, SOF_BYTE, 1'b0, '0},
		'{ROW_BYTE, SOF_BYTE, 1'b0, '0},
		'{ROW_BYTE, SOF_BYTE, 1'b0, '0}
	};

	// CRC-8 of the stored payload, fed one bit at a time through the LFSR
	function automatic logic [7:0] payload_crc();
		logic [31:0] msg;
		logic [7:0]  r;
		logic        fb;
		msg = {rx_pay[0], rx_pay[1], rx_pay[2], rx_pay[3]};
		r = 8'h00;
		for (int i = 31; i >= 0; i--) begin
			fb = r[7] ^ msg[i];
			r = {r[6:0], 1'b0};
			if (fb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	// advance the decoder by one accepted byte; returns 1 when a result is owed
	function automatic bit decode_byte(input logic [7:0] b, output rx_result_t res);
		bit owed;
		res = '0;
		owed = 1'b0;
		case (rx_phase)
			PH_HUNT: begin
				if (b == SOF_BYTE) begin
					rx_cnt = 3'd0;
					rx_phase = PH_COLLECT;
				end
			end
			PH_COLLECT: begin
				rx_pay[rx_cnt[1:0]] = b;
				rx_cnt = rx_cnt + 3'd1;
				if (rx_cnt >= PAYLOAD_LEN) begin
					rx_phase = PH_CHECK;
				end
			end
			default: begin
				// check position; an unused phase code lands here as well
				owed = 1'b1;
				if (b == payload_crc()) begin
					res.kind   = RK_FRAME;
					res.data   = {rx_pay[1][6:0], rx_pay[0]};
					res.redun  = {rx_pay[3][1:0], rx_pay[2]};
					res.parity = rx_pay[1][7];
					res.errs   = rx_errs;
				end else begin
					rx_errs = rx_errs + 1'b1;
					res.kind   = RK_MISMATCH;
					res.errs   = rx_errs;
					res.marker = marker_en;
				end
				rx_phase = PH_HUNT;
			end
		endcase
		return owed;
	endfunction

	function automatic int draw_gap(input int mode);
		if (mode == IDLE_FULL) begin
			return $urandom_range(0, 12);
		end
		if (mode == IDLE_SOME && $urandom_range(0, 3) == 0) begin
			return $urandom_range(0, 12);
		end
		return 0;
	endfunction

	// Send one byte request and log what it owes. Called and returns at a
	// falling edge; valid stays high when the next call has no gap.
	task automatic push_byte(input logic [7:0] b, input bit pin = 1'b0,
			input rx_result_t pinned = '0);
		int         gap;
		bit         owed;
		rx_result_t res;
		gap = draw_gap(in_mode);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		n_bytes++;
		if (rx_phase != PH_HUNT || b == SOF_BYTE) begin
			n_live++;
		end
		owed = decode_byte(b, res);
		if (owed) begin
			frame_results_q.push_back(pin ? pinned : res);
			if (res.kind == RK_FRAME) begin
				n_good++;
			end else begin
				n_bad++;
				if (res.marker) begin
					n_marked++;
				end
				if (res.errs == '0) begin
					wrap_seen = 1'b1;
				end
			end
		end
		@(negedge clk);
	endtask

	// hold off the sender until every owed result is out, then let the
	// pipeline settle
	task automatic drain_results();
		in_valid <= 1'b0;
		while (frame_results_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_marker_enable(input logic v);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		marker_en = v;
		n_cfg++;
	endtask

	// optional hunt noise, start byte, four payload bytes, then a check byte
	task automatic send_frame(input row_kind_t how);
		int         n_noise;
		logic [7:0] b;
		n_noise = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 3) : 0;
		repeat (n_noise) begin
			b = 8'($urandom_range(0, 255));
			if (b == SOF_BYTE) begin
				b = ~b;
			end
			push_byte(b);
		end
		push_byte(SOF_BYTE);
		repeat (PAYLOAD_LEN) begin
			b = ($urandom_range(0, 7) == 0) ? SOF_BYTE : 8'($urandom_range(0, 255));
			push_byte(b);
		end
		case (how)
			ROW_GOOD: b = payload_crc();
			ROW_BAD:  b = payload_crc() ^ 8'($urandom_range(1, 255));
			default:  b = 8'($urandom_range(0, 255));
		endcase
		push_byte(b);
	endtask

	// ------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Result side: per request, a random stall before ready goes high,
	// then ready holds until a request is taken.
	// ------------------------------------------------------------------
	initial begin
		int gap;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = draw_gap(out_mode);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// ------------------------------------------------------------------
	// Result checker: every accepted request against the oldest owed one
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		rx_result_t got;
		rx_result_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{result_kind, data_word, redundancy_word, parity_bit,
				error_count, marker_request};
			if (frame_results_q.size() == 0) begin
				n_fail++;
				if (n_fail <= MAX_REPORTS) begin
					$display("[%0t] unexpected result: kind=%0d data=%h redun=%h par=%0d errs=%0d mark=%0d",
						$realtime, got.kind, got.data, got.redun, got.parity, got.errs,
						got.marker);
				end
			end else begin
				want = frame_results_q.pop_front();
				if (got.kind !== want.kind || got.data !== want.data ||
						got.redun !== want.redun || got.parity !== want.parity ||
						got.errs !== want.errs || got.marker !== want.marker) begin
					n_fail++;
					if (n_fail <= MAX_REPORTS) begin
						$display("[%0t] result mismatch: exp kind=%0d data=%h redun=%h par=%0d errs=%0d mark=%0d",
							$realtime, want.kind, want.data, want.redun, want.parity,
							want.errs, want.marker);
						$display("[%0t]                  got kind=%0d data=%h redun=%h par=%0d errs=%0d mark=%0d",
							$realtime, got.kind, got.data, got.redun, got.parity,
							got.errs, got.marker);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: too long with no request moving on either channel
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("[%0t] no progress for %0d cycles", $realtime, STALL_LIMIT);
				$display("sof_crc8_frame_receiver_top verification failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		int         start;
		int         r;
		logic [7:0] b;

		// every input known from time zero; decoder starts in its reset state
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = 1'b0;
		in_valid    = 1'b0;
		rx_byte     = 8'h00;
		rx_phase    = PH_HUNT;
		rx_cnt      = 3'd0;
		rx_errs     = '0;
		marker_en   = 1'b0;
		for (int i = 0; i < PAYLOAD_LEN; i++) begin
			rx_pay[i] = 8'h00;
		end
		in_mode      = IDLE_NONE;
		out_mode     = IDLE_NONE;
		n_fail       = 0;
		n_live       = 0;
		n_bytes      = 0;
		n_good       = 0;
		n_bad        = 0;
		n_marked     = 0;
		n_cfg        = 0;
		stall_cycles = 0;
		wrap_seen    = 1'b0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table, with random gaps on both sides
		in_mode  = IDLE_FULL;
		out_mode = IDLE_FULL;
		for (int i = 0; i < N_DIR; i++) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				set_marker_enable(dir_rows[i].val[0]);
			end else begin
				case (dir_rows[i].kind)
					ROW_GOOD: b = payload_crc();
					ROW_BAD:  b = payload_crc() ^ dir_rows[i].val;
					default:  b = dir_rows[i].val;
				endcase
				push_byte(b, dir_rows[i].pinned, dir_rows[i].want);
			end
		end

		// Random phases. Each one sets its own marker setting and idle mix,
		// so gaps land on hunt, collect and check bytes alike, and the first
		// phase runs back to back with no idling at all.
		for (int ph = 0; ph < 6; ph++) begin
			set_marker_enable(ph[0]);
			in_mode  = ph % 3;
			out_mode = (ph / 3 + ph) % 3;
			start = n_live;
			while (n_live - start < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 8) begin
					// broken sequence: raw bytes that can cut into a frame
					repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)));
				end else if (r < 10) begin
					// sender waits until everything owed has come out
					drain_results();
				end else begin
					r = $urandom_range(0, 9);
					send_frame(r < 6 ? ROW_GOOD : (r < 9 ? ROW_BAD : ROW_BYTE));
				end
			end
		end

		// short back-to-back burst with markers on, mixed good and bad frames
		set_marker_enable(1'b1);
		in_mode  = IDLE_NONE;
		out_mode = IDLE_NONE;
		send_frame(ROW_BAD);
		send_frame(ROW_GOOD);
		send_frame(ROW_BAD);
		send_frame(ROW_GOOD);

		// back to the reset setting for a short tail with idling
		set_marker_enable(1'b0);
		in_mode  = IDLE_FULL;
		out_mode = IDLE_FULL;
		repeat (8) begin
			send_frame(($urandom_range(0, 1) == 0) ? ROW_GOOD : ROW_BAD);
		end

		drain_results();

		$display("run covered %0d bytes (%0d past the hunt), %0d good frames, %0d crc mismatches",
			n_bytes, n_live, n_good, n_bad);
		$display("  %0d with marker set, %0d config writes, error count wrap %s",
			n_marked, n_cfg, wrap_seen ? "reached" : "not reached");
		if (n_fail == 0) begin
			$display("sof_crc8_frame_receiver_top verification clean");
		end else begin
			$display("%0d result errors", n_fail);
			$display("sof_crc8_frame_receiver_top verification failed");
		end
		$finish;
	end

endmodule
